>>> rtl/csr_sparse_matvec_defines.svh
// Assertion macros for the sparse matrix-vector block.
`ifndef CSR_SPARSE_MATVEC_DEFINES_SVH
`define CSR_SPARSE_MATVEC_DEFINES_SVH

`ifndef SYNTHESIS

`define CSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("csm assertion failed");

`define CSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    `CSM_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`define CSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `CSM_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`else

`define CSM_ASSERT(lbl, clk, rst_n, prop)

`define CSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define CSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/csm_pkg.sv
package csm_pkg;

    localparam int unsigned VEC_DEPTH_DEF = 4096;

    localparam int IDX_W = 12;
    localparam int VAL_W = 32;
    localparam int ACC_W = 48;
    localparam int PROD_W = 2 * VAL_W;
    localparam int OP_W = 2;

    localparam int S_TDATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int S_PAD_W = S_TDATA_W - IDX_W - VAL_W;
    localparam int M_TDATA_W = ((VAL_W + IDX_W + 7) / 8) * 8;
    localparam int M_PAD_W = M_TDATA_W - VAL_W - IDX_W;

    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_ENTRY     = 2'd1,
        OP_EMPTY_END = 2'd2
    } t_op;

    typedef struct packed {
        logic             saturated;
        logic [IDX_W-1:0] row_number;
        logic [VAL_W-1:0] row_sum;
    } t_out_beat;

endpackage

>>> rtl/csm_out_fifo.sv
module csm_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  csm_pkg::t_out_beat               i_din,
    output logic                             o_valid,
    input  logic                             i_ready,
    output csm_pkg::t_out_beat               o_dout,
    output logic [csm_pkg::OFIFO_CW-1:0]     o_count
);
    import csm_pkg::*;

    t_out_beat             r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wr;
    logic [OFIFO_AW-1:0]   r_rd;
    logic [OFIFO_CW-1:0]   r_count;
    logic [OFIFO_CW-1:0]   n_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_dout  = r_mem[r_rd];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;
    assign n_count = r_count + OFIFO_CW'(i_push) - OFIFO_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/csr_sparse_matvec.sv
// Streaming y = A*x over a compressed-row matrix, Q16.16 signed fixed point.
// Load beats (tuser 0) write x into a single-port vector store and reset the
// row number; entry beats (tuser 1) multiply by the stored x and accumulate
// into a 48-bit saturating sum, and the beat with tlast set emits the row;
// tuser 2 emits a zero row. One beat is taken every cycle while tready is
// high. A row result passes through store read, 32x32 multiply, accumulate,
// and a clamp into an 8-deep output queue. tready drops while the queue
// plus rows still in flight could fill it, so a stalled consumer backs up
// the input once the queue and rows in flight reach its depth. An x
// element must be loaded before an entry reads it; indexes at or beyond
// VEC_DEPTH read as zero and are not stored.
`include "csr_sparse_matvec_defines.svh"

module csr_sparse_matvec #(
    parameter int unsigned VEC_DEPTH = csm_pkg::VEC_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [11:0] index, [43:12] value, [47:44] zero
    input  logic [csm_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // [1:0] op
    input  logic [csm_pkg::OP_W-1:0]         i_s_axis_tuser,
    // row_end
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] row_sum, [43:32] row_number, [47:44] zero
    output logic [csm_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] saturated
    output logic                             o_m_axis_tuser
);
    import csm_pkg::*;

    localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic [VAL_W-1:0]     r_vec [VEC_DEPTH];

    logic                 s_hs;
    logic [IDX_W-1:0]     in_index;
    logic [VAL_W-1:0]     in_value;
    logic                 in_ok;
    logic                 is_load;
    logic                 is_entry;
    logic                 is_empty;
    logic [AW-1:0]        in_addr;

    logic [IDX_W-1:0]     r_row_cnt;
    logic [IDX_W-1:0]     n_row_cnt;

    // stage 1: store read
    logic                 r_p1_vld;
    logic                 r_p1_entry;
    logic                 r_p1_last;
    logic                 r_p1_ok;
    logic [IDX_W-1:0]     r_p1_row;
    logic [VAL_W-1:0]     r_p1_val;
    logic [VAL_W-1:0]     r_x;
    logic signed [VAL_W-1:0] x_eff;

    // stage 2: product
    logic                 r_p2_vld;
    logic                 r_p2_entry;
    logic                 r_p2_last;
    logic [IDX_W-1:0]     r_p2_row;
    logic signed [PROD_W-1:0] r_prod;

    // stage 3: accumulate
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic                 r_sat_flag;
    logic                 n_sat_flag;
    logic signed [ACC_W-1:0] prod_q;
    logic signed [ACC_W:0]   sum_ext;
    logic signed [ACC_W-1:0] sum_clamp;
    logic                 sum_ovf;

    logic                 r_e_vld;
    logic signed [ACC_W-1:0] r_e_sum;
    logic                 r_e_sat;
    logic [IDX_W-1:0]     r_e_row;

    t_out_beat            push_beat;
    t_out_beat            q_beat;
    logic                 out_ovf;
    logic [OFIFO_CW-1:0]  q_count;
    logic [OFIFO_CW-1:0]  credit;
    logic                 e1;
    logic                 e2;

    // input side
    assign in_index = i_s_axis_tdata[IDX_W-1:0];
    assign in_value = i_s_axis_tdata[IDX_W +: VAL_W];
    assign in_ok    = (32'(in_index) < 32'(VEC_DEPTH));
    assign in_addr  = AW'(in_index);
    assign is_load  = (i_s_axis_tuser == OP_LOAD);
    assign is_entry = (i_s_axis_tuser == OP_ENTRY);
    assign is_empty = (i_s_axis_tuser == OP_EMPTY_END);
    assign s_hs     = i_s_axis_tvalid && o_s_axis_tready;

    assign e1     = r_p1_vld && (!r_p1_entry || r_p1_last);
    assign e2     = r_p2_vld && (!r_p2_entry || r_p2_last);
    assign credit = q_count + OFIFO_CW'(e1) + OFIFO_CW'(e2) + OFIFO_CW'(r_e_vld);
    assign o_s_axis_tready = i_rst_n && (credit < OFIFO_CW'(OFIFO_DEPTH));

    always_comb begin
        n_row_cnt = r_row_cnt;
        if (s_hs) begin
            if (is_load) begin
                n_row_cnt = '0;
            end else if (is_empty || (is_entry && i_s_axis_tlast)) begin
                n_row_cnt = r_row_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_hs && is_load && in_ok) begin
            r_vec[in_addr] <= in_value;
        end
        if (s_hs) begin
            r_x <= r_vec[in_addr];
        end
    end

    // product
    assign x_eff = r_p1_ok ? $signed(r_x) : '0;

    always_ff @(posedge i_clk) begin
        r_p1_entry <= is_entry;
        r_p1_last  <= i_s_axis_tlast;
        r_p1_ok    <= in_ok;
        r_p1_row   <= r_row_cnt;
        r_p1_val   <= in_value;
        r_p2_entry <= r_p1_entry;
        r_p2_last  <= r_p1_last;
        r_p2_row   <= r_p1_row;
        r_prod     <= $signed(r_p1_val) * x_eff;
    end

    // accumulate with 48-bit clamp
    assign prod_q    = r_prod[PROD_W-1 -: ACC_W];
    assign sum_ext   = {r_acc[ACC_W-1], r_acc} + {prod_q[ACC_W-1], prod_q};
    assign sum_ovf   = (sum_ext[ACC_W] != sum_ext[ACC_W-1]);
    assign sum_clamp = sum_ovf ? (sum_ext[ACC_W] ? ACC_MIN : ACC_MAX)
                               : sum_ext[ACC_W-1:0];

    always_comb begin
        n_acc      = r_acc;
        n_sat_flag = r_sat_flag;
        if (r_p2_vld) begin
            if (!r_p2_entry || r_p2_last) begin
                n_acc      = '0;
                n_sat_flag = 1'b0;
            end else begin
                n_acc      = sum_clamp;
                n_sat_flag = r_sat_flag || sum_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_row <= r_p2_row;
        r_e_sum <= r_p2_entry ? sum_clamp : '0;
        r_e_sat <= r_p2_entry && (r_sat_flag || sum_ovf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= '0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_e_vld    <= 1'b0;
            r_acc      <= '0;
            r_sat_flag <= 1'b0;
        end else begin
            r_row_cnt  <= n_row_cnt;
            r_p1_vld   <= s_hs && (is_entry || is_empty);
            r_p2_vld   <= r_p1_vld;
            r_e_vld    <= e2;
            r_acc      <= n_acc;
            r_sat_flag <= n_sat_flag;
        end
    end

    // 32-bit output clamp
    assign out_ovf = !((&r_e_sum[ACC_W-1:VAL_W-1]) || !(|r_e_sum[ACC_W-1:VAL_W-1]));

    always_comb begin
        push_beat.row_number = r_e_row;
        push_beat.saturated  = r_e_sat || out_ovf;
        if (out_ovf) begin
            push_beat.row_sum = r_e_sum[ACC_W-1] ? OUT_MIN : OUT_MAX;
        end else begin
            push_beat.row_sum = r_e_sum[VAL_W-1:0];
        end
    end

    csm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_e_vld),
        .i_din   (push_beat),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_dout  (q_beat),
        .o_count (q_count)
    );

    assign o_m_axis_tdata = {{M_PAD_W{1'b0}}, q_beat.row_number, q_beat.row_sum};
    assign o_m_axis_tuser = q_beat.saturated;

    `CSM_ASSERT_NEXT(a_load_clears_row, i_clk, i_rst_n, s_hs && is_load, r_row_cnt == '0)
    `CSM_ASSERT_IMPL(a_no_queue_overflow, i_clk, i_rst_n, r_e_vld, q_count < OFIFO_CW'(OFIFO_DEPTH))
    `CSM_ASSERT_IMPL(a_row_end_clears_acc, i_clk, i_rst_n, r_e_vld, r_acc == '0 && !r_sat_flag)

endmodule

>>> sim/csr_sparse_matvec_tb.sv
`timescale 1ns / 100ps

module csr_sparse_matvec_tb;
    import csm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RAND_BEATS = 1280;
    localparam int CALM_BEATS = 150;
    localparam int DIR_N = 24;
    localparam longint ACC_MAX = (longint'(1) <<< 47) - 1;
    localparam longint ACC_MIN = -(longint'(1) <<< 47);
    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             last;
        logic             typed;
        logic [VAL_W-1:0] sum;
        logic [IDX_W-1:0] row;
        logic             sat;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [OP_W-1:0]      i_s_axis_tuser = '0;
    logic                 i_s_axis_tlast = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    // vector store mirror and row state
    logic [VAL_W-1:0] x_mirror [VEC_DEPTH_DEF];
    bit               x_loaded [VEC_DEPTH_DEF];
    logic [IDX_W-1:0] loaded_q [$];
    longint           acc_mirror = 0;
    logic [IDX_W-1:0] row_mirror = '0;
    bit               sat_mirror = 1'b0;

    t_out_beat row_sums_q [$];
    t_out_beat got_beat;
    t_out_beat want_beat;

    int  errors = 0;
    int  beats_sent = 0;
    int  rows_checked = 0;
    int  sat_rows = 0;
    int  idle_cnt = 0;
    bit  calm = 1'b0;

    t_dir_row dir_rows [DIR_N] = '{
        '{OP_EMPTY_END, 12'd0,    32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 12'd0, 1'b0},
        '{OP_LOAD,      12'd0,    32'h0001_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_LOAD,      12'd4095, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_LOAD,      12'd1,    32'h8000_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_LOAD,      12'd2,    32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd0,    32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 12'd0, 1'b0},
        '{OP_ENTRY,     12'd4095, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 12'd1, 1'b1},
        '{OP_ENTRY,     12'd1,    32'h8000_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd1,    32'h8000_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd0,    32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 12'd2, 1'b1},
        '{OP_ENTRY,     12'd4095, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd4095, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd4095, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd0,    32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, 12'd3, 1'b1},
        '{OP_ENTRY,     12'd2,    32'h0000_0001, 1'b1, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd0,    32'h0001_2345, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_EMPTY_END, 12'hABC,  32'h5A5A_5A5A, 1'b1, 1'b1, 32'h0000_0000, 12'd5, 1'b0},
        '{OP_UNUSED,    12'hFFF,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_LOAD,      12'd3,    32'h0002_0000, 1'b1, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd3,    32'hFFFF_0000, 1'b1, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd0,    32'h0001_0000, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_LOAD,      12'd5,    32'h0000_0005, 1'b0, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_ENTRY,     12'd5,    32'h0001_0000, 1'b1, 1'b0, 32'h0,         12'd0, 1'b0},
        '{OP_EMPTY_END, 12'd0,    32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 12'd1, 1'b0}
    };

    csr_sparse_matvec uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit predict_row_sum(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
            input logic [VAL_W-1:0] val, input logic last, output t_out_beat res);
        longint xv;
        longint prod;
        longint sum;
        bit     osat;
        res = '0;
        osat = 1'b0;
        case (op)
            OP_LOAD: begin
                if (int'(idx) < VEC_DEPTH_DEF)
                    x_mirror[idx] = val;
                row_mirror = '0;
                return 1'b0;
            end
            OP_ENTRY: begin
                xv = 0;
                if (int'(idx) < VEC_DEPTH_DEF)
                    xv = longint'($signed(x_mirror[idx]));
                prod = (longint'($signed(val)) * xv) >>> 16;
                sum = acc_mirror + prod;
                if (sum > ACC_MAX) begin
                    sum = ACC_MAX;
                    sat_mirror = 1'b1;
                end else if (sum < ACC_MIN) begin
                    sum = ACC_MIN;
                    sat_mirror = 1'b1;
                end
                acc_mirror = sum;
                if (!last)
                    return 1'b0;
                if (sum > OUT_MAX) begin
                    sum = OUT_MAX;
                    osat = 1'b1;
                end else if (sum < OUT_MIN) begin
                    sum = OUT_MIN;
                    osat = 1'b1;
                end
                res.row_sum = sum[VAL_W-1:0];
                res.row_number = row_mirror;
                res.saturated = sat_mirror | osat;
                acc_mirror = 0;
                sat_mirror = 1'b0;
                row_mirror = row_mirror + 1'b1;
                return 1'b1;
            end
            OP_EMPTY_END: begin
                res.row_number = row_mirror;
                acc_mirror = 0;
                sat_mirror = 1'b0;
                row_mirror = row_mirror + 1'b1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] any_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4, 5, 6: return {{14{r[17]}}, r[17:0]};
            default: return r;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_loaded();
        return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
    endfunction

    // one input beat; returns once accepted, with the expected row queued
    task automatic push_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
            input logic [VAL_W-1:0] val, input logic last, input bit use_typed = 1'b0,
            input t_out_beat typed_res = '0);
        t_out_beat res;
        bit        has_res;
        if (!calm && $urandom_range(0, 11) == 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {{S_PAD_W{1'b0}}, val, idx};
        i_s_axis_tuser <= op;
        i_s_axis_tlast <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_sent++;
        if (op == OP_LOAD && !x_loaded[idx]) begin
            x_loaded[idx] = 1'b1;
            loaded_q.push_back(idx);
        end
        has_res = predict_row_sum(op, idx, val, last, res);
        if (has_res)
            row_sums_q.push_back(use_typed ? typed_res : res);
    endtask

    task automatic entry_row(input int n);
        for (int k = 0; k < n; k++)
            push_beat(OP_ENTRY, pick_loaded(), any_value(), k == n - 1);
    endtask

    task automatic random_phase();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12 || loaded_q.size() == 0) begin
            repeat ($urandom_range(1, 12))
                push_beat(OP_LOAD, IDX_W'($urandom_range(0, 4095)), any_value(), 1'b0);
        end else if (pick < 22) begin
            push_beat(OP_EMPTY_END, IDX_W'($urandom_range(0, 4095)), $urandom,
                      1'($urandom_range(0, 1)));
        end else if (pick < 88) begin
            entry_row($urandom_range(1, 6));
        end else if (pick < 92) begin
            push_beat(OP_UNUSED, IDX_W'($urandom_range(0, 4095)), $urandom,
                      1'($urandom_range(0, 1)));
        end else if (pick < 96) begin
            // row cut short, partial sum dropped
            repeat ($urandom_range(1, 3))
                push_beat(OP_ENTRY, pick_loaded(), any_value(), 1'b0);
            push_beat(OP_EMPTY_END, IDX_W'($urandom_range(0, 4095)), $urandom,
                      1'($urandom_range(0, 1)));
        end else begin
            // load lands inside a row
            push_beat(OP_ENTRY, pick_loaded(), any_value(), 1'b0);
            push_beat(OP_LOAD, IDX_W'($urandom_range(0, 4095)), any_value(),
                      1'($urandom_range(0, 1)));
            entry_row($urandom_range(1, 3));
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
    end

    initial begin
        wait (idle_cnt >= WATCHDOG_LIMIT);
        $display("watchdog: no beat for %0d cycles, %0d rows outstanding",
                 WATCHDOG_LIMIT, row_sums_q.size());
        $display("[csr_sparse_matvec] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_beat = {o_m_axis_tuser, o_m_axis_tdata[VAL_W+IDX_W-1:0]};
            if (row_sums_q.size() == 0) begin
                $error("unexpected row beat: row %0d sum %h", got_beat.row_number,
                       got_beat.row_sum);
                errors++;
            end else begin
                want_beat = row_sums_q.pop_front();
                rows_checked++;
                if (want_beat.saturated)
                    sat_rows++;
                if (got_beat.row_sum !== want_beat.row_sum) begin
                    $error("row_sum: expected %h, got %h", want_beat.row_sum, got_beat.row_sum);
                    errors++;
                end
                if (got_beat.row_number !== want_beat.row_number) begin
                    $error("row_number: expected %0d, got %0d", want_beat.row_number,
                           got_beat.row_number);
                    errors++;
                end
                if (got_beat.saturated !== want_beat.saturated) begin
                    $error("saturated: expected %b, got %b", want_beat.saturated,
                           got_beat.saturated);
                    errors++;
                end
            end
        end
    end

    // output back-pressure
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int calm_stop;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            push_beat(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].last,
                      dir_rows[i].typed,
                      '{saturated: dir_rows[i].sat, row_number: dir_rows[i].row,
                        row_sum: dir_rows[i].sum});

        while (beats_sent < DIR_N + RAND_BEATS)
            random_phase();

        calm = 1'b1;
        calm_stop = beats_sent + CALM_BEATS;
        while (beats_sent < calm_stop)
            random_phase();

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (row_sums_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input beats (loads, entries, empty rows, unused codes), stalls on both sides",
                 beats_sent);
        $display("%0d row results checked, %0d of them saturated", rows_checked, sat_rows);
        if (errors == 0)
            $display("[csr_sparse_matvec] OK");
        else
            $display("[csr_sparse_matvec] ERROR");
        $finish;
    end

endmodule

>>> csr_sparse_matvec.f
+incdir+rtl
rtl/csm_pkg.sv
rtl/csm_out_fifo.sv
rtl/csr_sparse_matvec.sv
sim/csr_sparse_matvec_tb.sv
